// ===== rtl/mpq_pkg.sv =====
// Package for the min-priority queue: sizes, codes, and the structs passed between modules.
// Depends on nothing; every other file of the block uses it, the RTL by scoped names and the testbench by import.
`timescale 1ns / 1ps

package mpq_pkg;

    // Number of keys the queue can hold.
    localparam int CAPACITY = 8;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [CNT_W:0]          cnt_ext_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [OCC_W-1:0]        occ_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation codes.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    // Access request from the controller to the key memory.
    typedef struct packed {
        logic  we;
        addr_t waddr;
        key_t  wdata;
        logic  re;
        addr_t raddr;
    } ram_req_t;

    // Finished result handed from the controller to the output register.
    typedef struct packed {
        logic    valid;
        status_t status;
        key_t    key;
        occ_t    occupancy;
    } result_t;

    // Count as reported in the 4-bit occupancy field (wraps above 15).
    function automatic occ_t occ_of(cnt_t c);
        logic [CNT_W+OCC_W-1:0] w;
        w = {{OCC_W{1'b0}}, c};
        return w[OCC_W-1:0];
    endfunction

endpackage

// ===== rtl/mpq_req_if.sv =====
// Request channel of the min-priority queue: valid/ready handshake with command and key.
// Depends on mpq_pkg for the key width.
`timescale 1ns / 1ps

interface mpq_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    mpq_pkg::key_t      key_in;

    modport source (output valid, output cmd, output key_in, input ready);
    modport sink   (input valid, input cmd, input key_in, output ready);
endinterface

// ===== rtl/mpq_rsp_if.sv =====
// Response channel of the min-priority queue: valid/ready handshake with status, key and count.
// Depends on mpq_pkg for the field widths.
`timescale 1ns / 1ps

interface mpq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [mpq_pkg::STATUS_W-1:0]    status;
    mpq_pkg::key_t                   key_out;
    mpq_pkg::occ_t                   occupancy;

    modport source (output valid, output status, output key_out, output occupancy, input ready);
    modport sink   (input valid, input status, input key_out, input occupancy, output ready);
endinterface

// ===== rtl/mpq_key_ram.sv =====
// Key store of the queue: one write port and one read port with registered read data.
// Depends on mpq_pkg for sizes and the request struct.
`timescale 1ns / 1ps

module mpq_key_ram (
    input  logic              clk,
    input  mpq_pkg::ram_req_t req,
    output mpq_pkg::key_t     rdata
);

    mpq_pkg::key_t mem [mpq_pkg::CAPACITY];
    mpq_pkg::key_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port; data holds between reads.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mpq_ctrl.sv =====
// Sequencer of the queue: takes a transaction, appends an insert, or scans the key memory for the
// smallest key and closes the gap by shifting later keys down; hands out one result. Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_cmd,
    input  mpq_pkg::key_t      in_key,
    input  logic               slot_free,
    output mpq_pkg::result_t   result,
    output mpq_pkg::ram_req_t  ram_req,
    input  mpq_pkg::key_t      ram_rdata
);

    mpq_pkg::state_t  state_reg, state_next;
    mpq_pkg::cnt_t    count_reg, count_next;
    mpq_pkg::cnt_t    idx_reg, idx_next;
    mpq_pkg::cnt_t    data_idx_reg, data_idx_next;
    mpq_pkg::cnt_t    pos_reg, pos_next;
    mpq_pkg::key_t    best_reg, best_next;
    mpq_pkg::status_t pend_status_reg, pend_status_next;
    mpq_pkg::key_t    pend_key_reg, pend_key_next;

    logic             is_full;
    logic             is_empty;
    logic             scan_take;
    logic             scan_last;
    logic             shift_needed;
    logic             shift_last;
    mpq_pkg::key_t    best_new;
    mpq_pkg::cnt_t    pos_new;
    mpq_pkg::cnt_t    pos_plus1;
    mpq_pkg::cnt_ext_t idx_plus2;

    // Conditions on the stored count and the scan/shift progress.
    assign is_full      = (count_reg == mpq_pkg::cnt_t'(mpq_pkg::CAPACITY));
    assign is_empty     = (count_reg == '0);
    assign scan_take    = (data_idx_reg == '0) || (ram_rdata < best_reg);
    assign best_new     = scan_take ? ram_rdata : best_reg;
    assign pos_new      = scan_take ? data_idx_reg : pos_reg;
    assign scan_last    = (data_idx_reg == count_reg - mpq_pkg::cnt_t'(1));
    assign pos_plus1    = pos_new + mpq_pkg::cnt_t'(1);
    assign shift_needed = ({1'b0, pos_new} + mpq_pkg::cnt_ext_t'(1)) < {1'b0, count_reg};
    assign idx_plus2    = {1'b0, idx_reg} + mpq_pkg::cnt_ext_t'(2);
    assign shift_last   = (idx_plus2 >= {1'b0, count_reg});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if ((in_cmd == mpq_pkg::CMD_REMOVE) && !is_empty)
                    begin
                        state_next = mpq_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = mpq_pkg::S_FINISH;
                    end
                end
            end
            mpq_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = shift_needed ? mpq_pkg::S_SHIFT : mpq_pkg::S_FINISH;
                end
            end
            mpq_pkg::S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = mpq_pkg::S_FINISH;
                end
            end
            mpq_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = mpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mpq_pkg::S_IDLE;
            end
        endcase
    end

    // Memory requests, handshake and datapath updates per state.
    always_comb
    begin
        in_ready         = (state_reg == mpq_pkg::S_IDLE);
        ram_req          = '0;
        count_next       = count_reg;
        idx_next         = idx_reg;
        data_idx_next    = data_idx_reg;
        pos_next         = pos_reg;
        best_next        = best_reg;
        pend_status_next = pend_status_reg;
        pend_key_next    = pend_key_reg;
        unique case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    pend_status_next = mpq_pkg::ST_OK;
                    pend_key_next    = '0;
                    if (in_cmd == mpq_pkg::CMD_INSERT)
                    begin
                        if (is_full)
                        begin
                            pend_status_next = mpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            // Append at the end of the list.
                            ram_req.we    = 1'b1;
                            ram_req.waddr = count_reg[mpq_pkg::ADDR_W-1:0];
                            ram_req.wdata = in_key;
                            count_next    = count_reg + mpq_pkg::cnt_t'(1);
                        end
                    end
                    else if (is_empty)
                    begin
                        pend_status_next = mpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Start the scan with the first entry.
                        ram_req.re    = 1'b1;
                        ram_req.raddr = '0;
                        idx_next      = mpq_pkg::cnt_t'(1);
                        data_idx_next = '0;
                    end
                end
            end
            mpq_pkg::S_SCAN:
            begin
                best_next = best_new;
                pos_next  = pos_new;
                if (scan_last)
                begin
                    pend_key_next = best_new;
                    if (shift_needed)
                    begin
                        // Fetch the entry just above the removed one.
                        ram_req.re    = 1'b1;
                        ram_req.raddr = pos_plus1[mpq_pkg::ADDR_W-1:0];
                        idx_next      = pos_new;
                    end
                    else
                    begin
                        count_next = count_reg - mpq_pkg::cnt_t'(1);
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[mpq_pkg::ADDR_W-1:0];
                    data_idx_next = idx_reg;
                    idx_next      = idx_reg + mpq_pkg::cnt_t'(1);
                end
            end
            mpq_pkg::S_SHIFT:
            begin
                // Move the fetched entry down one place and fetch the next.
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[mpq_pkg::ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
                if (shift_last)
                begin
                    count_next = count_reg - mpq_pkg::cnt_t'(1);
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_plus2[mpq_pkg::ADDR_W-1:0];
                    idx_next      = idx_reg + mpq_pkg::cnt_t'(1);
                end
            end
            mpq_pkg::S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result handed to the output register.
    always_comb
    begin
        result.valid     = (state_reg == mpq_pkg::S_FINISH) && slot_free;
        result.status    = pend_status_reg;
        result.key       = pend_key_reg;
        result.occupancy = mpq_pkg::occ_of(count_reg);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpq_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the scan and shift.
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        data_idx_reg    <= data_idx_next;
        pos_reg         <= pos_next;
        best_reg        <= best_next;
        pend_status_reg <= pend_status_next;
        pend_key_reg    <= pend_key_next;
    end

endmodule

// ===== rtl/min_priority_queue_core.sv =====
// Top level of the bounded min-priority queue: controller, key memory and output register.
// Depends on mpq_pkg, mpq_req_if, mpq_rsp_if, mpq_key_ram and mpq_ctrl.
//
// Usage:
//   req carries one command per transaction: insert key_in, or remove the smallest key.
//   rsp returns exactly one result per request: status (ok, full, empty), the removed
//   key (zero unless a remove succeeded) and the number of keys held afterwards.
//   An insert's result is loaded into the output register from the finish state once that
//   register is free, and is offered on rsp from the following cycle. A remove on a queue
//   of n keys scans all n keys, reading one stored key per cycle through the single memory
//   read port and comparing it against the running minimum, then shifts the keys above the
//   removed position p down one place, one write per cycle, each but the last with a read. Its
//   result is then loaded from the finish state in the same way. One request is processed at a
//   time: a new request is accepted only after the result of the last one is in the output register.
//   Reset empties the queue; the key memory itself is not cleared, since only
//   entries below the count are ever read.
//   The result sits in an output register, so the next request is accepted while an
//   earlier result still waits. If the receiver stalls with a result pending, the
//   next result is held inside until the register frees up.
`timescale 1ns / 1ps

module min_priority_queue_core (
    input  logic      clk,
    input  logic      rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp
);

    mpq_pkg::ram_req_t ram_req;
    mpq_pkg::key_t     ram_rdata;
    mpq_pkg::result_t  result;
    logic              slot_free;

    logic                         rsp_valid_reg;
    logic [mpq_pkg::STATUS_W-1:0] rsp_status_reg;
    mpq_pkg::key_t                rsp_key_reg;
    mpq_pkg::occ_t                rsp_occ_reg;

    // The output register can take a result when empty or being drained.
    assign slot_free = !rsp_valid_reg || rsp.ready;

    mpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_cmd    (req.cmd),
        .in_key    (req.key_in),
        .slot_free (slot_free),
        .result    (result),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    mpq_key_ram u_key_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            rsp_status_reg <= result.status;
            rsp_key_reg    <= result.key;
            rsp_occ_reg    <= result.occupancy;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.key_out   = rsp_key_reg;
    assign rsp.occupancy = rsp_occ_reg;

endmodule

// ===== rtl/mpq_checker.sv =====
// Port-level checks of the min-priority queue, attached to the top level by bind.
// Depends on mpq_pkg and min_priority_queue_core.
`timescale 1ns / 1ps

module mpq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [mpq_pkg::STATUS_W-1:0] rsp_status,
    input mpq_pkg::key_t                rsp_key_out,
    input mpq_pkg::occ_t                rsp_occupancy
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_key_out) && $stable(rsp_occupancy))
    else $error("stalled result changed or was dropped");

    // Only defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == mpq_pkg::ST_OK) || (rsp_status == mpq_pkg::ST_FULL)
            || (rsp_status == mpq_pkg::ST_EMPTY))
    else $error("undefined status code");

    // A refused insert reports a full queue and no key.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == mpq_pkg::ST_FULL) |->
            (rsp_occupancy == mpq_pkg::occ_of(mpq_pkg::cnt_t'(mpq_pkg::CAPACITY)))
            && (rsp_key_out == '0))
    else $error("full status with wrong count or key");

    // A refused remove reports an empty queue and no key.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == mpq_pkg::ST_EMPTY) |->
            (rsp_occupancy == '0) && (rsp_key_out == '0))
    else $error("empty status with wrong count or key");

    // Each request keeps the block busy for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request accepted on back-to-back cycles");

endmodule

bind min_priority_queue_core mpq_checker u_mpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_key_out   (rsp.key_out),
    .rsp_occupancy (rsp.occupancy)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for min_priority_queue_core: directed table, then random traffic.
// Depends on mpq_pkg, mpq_req_if, mpq_rsp_if and the core; each response is checked against
// a behavioral model of the queue, or against the row's own response for typed directed rows.
`timescale 1ns / 1ps

module testbench;
    import mpq_pkg::*;

    localparam int RANDOM_ITEMS   = 926;
    localparam int QUIET_TAIL     = 150;
    localparam int HOLD_OFF_AT    = 300;
    localparam int PAUSE_AT       = 600;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam key_t KEY_MIN      = 32'sh8000_0000;
    localparam key_t KEY_MAX      = 32'sh7fff_ffff;

    // One expected response.
    typedef struct packed {
        status_t status;
        key_t    key;
        occ_t    occupancy;
    } response_t;

    // One row of the directed table; typed rows carry their own expected response.
    typedef struct packed {
        cmd_t      cmd;
        key_t      key;
        logic      typed;
        response_t resp;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_REMOVE, 32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 4'd0}},
        '{CMD_INSERT, KEY_MIN,         1'b1, '{ST_OK,    32'sd0, 4'd1}},
        '{CMD_INSERT, KEY_MAX,         1'b1, '{ST_OK,    32'sd0, 4'd2}},
        '{CMD_REMOVE, 32'sh5a5a_0000,  1'b1, '{ST_OK,    KEY_MIN, 4'd1}},
        '{CMD_REMOVE, 32'sd0,          1'b1, '{ST_OK,    KEY_MAX, 4'd0}},
        '{CMD_REMOVE, -32'sd1,         1'b1, '{ST_EMPTY, 32'sd0, 4'd0}},
        '{CMD_INSERT, 32'sd5,          1'b1, '{ST_OK,    32'sd0, 4'd1}},
        '{CMD_INSERT, -32'sd1,         1'b1, '{ST_OK,    32'sd0, 4'd2}},
        '{CMD_INSERT, 32'sd5,          1'b1, '{ST_OK,    32'sd0, 4'd3}},
        '{CMD_INSERT, 32'sd0,          1'b1, '{ST_OK,    32'sd0, 4'd4}},
        '{CMD_INSERT, -32'sd1,         1'b1, '{ST_OK,    32'sd0, 4'd5}},
        '{CMD_INSERT, KEY_MAX,         1'b1, '{ST_OK,    32'sd0, 4'd6}},
        '{CMD_INSERT, KEY_MIN,         1'b1, '{ST_OK,    32'sd0, 4'd7}},
        '{CMD_INSERT, 32'sh5555_5555,  1'b1, '{ST_OK,    32'sd0, 4'd8}},
        '{CMD_INSERT, 32'shaaaa_aaaa,  1'b1, '{ST_FULL,  32'sd0, 4'd8}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b0, '{ST_OK,    32'sd0, 4'd0}},
        '{CMD_REMOVE, 32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 4'd0}}
    };

    logic clk;
    logic rst_n;

    mpq_req_if req_ch ();
    mpq_rsp_if rsp_ch ();

    min_priority_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Keys held by the model, in arrival order.
    key_t      held_keys [$];
    response_t awaited_responses [$];

    int  error_count = 0;
    int  idle_cycles = 0;
    int  n_insert;
    int  n_remove;
    int  n_full;
    int  n_empty;
    bit  quiet_phase;
    bit  hold_off_request;

    // Apply one transaction to the model queue and return its response.
    function automatic response_t queue_op_outcome(cmd_t cmd, key_t key);
        response_t r;
        int        pos;
        r = '{ST_OK, 32'sd0, 4'd0};
        if (cmd == CMD_INSERT)
        begin
            n_insert++;
            if (held_keys.size() >= CAPACITY)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                held_keys.push_back(key);
            end
        end
        else
        begin
            n_remove++;
            if (held_keys.size() == 0)
            begin
                r.status = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                // First occurrence of the smallest key wins.
                pos = 0;
                for (int i = 1; i < held_keys.size(); i++)
                begin
                    if (held_keys[i] < held_keys[pos])
                        pos = i;
                end
                r.key = held_keys[pos];
                held_keys.delete(pos);
            end
        end
        r.occupancy = occ_t'(held_keys.size());
        return r;
    endfunction

    // Offer one transaction and wait until the core takes it.
    task automatic send_request(cmd_t cmd, key_t key, bit use_typed, response_t typed_resp);
        response_t predicted;
        req_ch.valid  <= 1'b1;
        req_ch.cmd    <= cmd;
        req_ch.key_in <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = queue_op_outcome(cmd, key);
        awaited_responses.push_back(use_typed ? typed_resp : predicted);
    endtask

    // Random idle burst on the request side, skipped in the quiet tail.
    task automatic maybe_gap();
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Keys lean toward extremes and a narrow band so that duplicates are common.
    function automatic key_t pick_key();
        case ($urandom_range(0, 7))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2, 3, 4: return key_t'($urandom_range(0, 6)) - 32'sd3;
            default: return key_t'($urandom());
        endcase
    endfunction

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset, then the request stream and the end of the run.
    initial
    begin
        int        insert_pct;
        cmd_t      cmd;
        response_t no_resp;
        no_resp          = '{ST_OK, 32'sd0, 4'd0};
        quiet_phase      = 1'b0;
        hold_off_request = 1'b0;
        insert_pct       = 50;
        rst_n            = 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= CMD_INSERT;
        req_ch.key_in   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, full, empty and duplicate smallest keys.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_request(directed_rows[i].cmd, directed_rows[i].key,
                         directed_rows[i].typed, directed_rows[i].resp);
            maybe_gap();
        end

        // Random traffic in phases that fill, drain or churn the queue.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 16 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                quiet_phase = 1'b1;
            if (i == HOLD_OFF_AT)
                hold_off_request = 1'b1;
            // Let every outstanding response come back before going on.
            if (i == PAUSE_AT)
            begin
                req_ch.valid <= 1'b0;
                while (awaited_responses.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            send_request(cmd, pick_key(), 1'b0, no_resp);
            maybe_gap();
        end

        req_ch.valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d inserts (%0d refused as full) and %0d removes (%0d on empty).",
                 n_insert, n_full, n_remove, n_empty);
        $display("Included a long response hold-off and a full drain pause mid-run.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Response side: random stall bursts, one long hold-off, steady in the quiet tail.
    initial
    begin
        bit hold_off_done;
        hold_off_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_request && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        response_t exp_resp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                error_count++;
                $error("Unexpected response transaction: status %0d key_out %0d occupancy %0d",
                       rsp_ch.status, rsp_ch.key_out, rsp_ch.occupancy);
            end
            else
            begin
                exp_resp = awaited_responses.pop_front();
                if (rsp_ch.status !== exp_resp.status)
                begin
                    error_count++;
                    $error("status: expected %0d, got %0d", exp_resp.status, rsp_ch.status);
                end
                if (rsp_ch.key_out !== exp_resp.key)
                begin
                    error_count++;
                    $error("key_out: expected %0d, got %0d", exp_resp.key, rsp_ch.key_out);
                end
                if (rsp_ch.occupancy !== exp_resp.occupancy)
                begin
                    error_count++;
                    $error("occupancy: expected %0d, got %0d",
                           exp_resp.occupancy, rsp_ch.occupancy);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel ends the run.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
